[src/point_in_polygon_crossing_top_macros.svh]
// assertion macros shared by the checker
`ifndef POINT_IN_POLYGON_CROSSING_TOP_MACROS_SVH
`define POINT_IN_POLYGON_CROSSING_TOP_MACROS_SVH

// consequent holds in the same cycle as the antecedent
`define PIPC_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("pipc check failed");

// consequent holds in the cycle after the antecedent
`define PIPC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("pipc check failed");

`endif

[src/pipc_pkg.sv]
`timescale 1ns / 1ps

package pipc_pkg;

  localparam int COORD_W  = 32;
  localparam int VCOUNT_W = 9;
  localparam int CMD_W    = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
  } request_t;

  typedef struct packed {
    logic                inside_res;
    logic                status;
    logic [VCOUNT_W-1:0] vertex_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic op_done;
    logic query_start;
    logic rd_issue;
    logic query_finish;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic few_vertices;
    logic last_issue;
    logic pipe_busy;
  } stat_t;

endpackage

[src/pipc_ctrl.sv]
`timescale 1ns / 1ps

module pipc_ctrl import pipc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [CMD_W-1:0] command,
  input  stat_t            stat,
  output ctrl_t            ctrl,
  output logic             busy
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0] state, state_next;

  // next state and command decode
  always_comb begin
    ctrl       = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (command == CMD_QUERY && !stat.few_vertices) begin
            ctrl.query_start = 1'b1;
            state_next       = S_WALK;
          end else begin
            ctrl.op_done = 1'b1;
          end
        end
      end
      S_WALK: begin
        ctrl.rd_issue = 1'b1;
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          ctrl.query_finish = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

[src/pipc_dp.sv]
`timescale 1ns / 1ps

module pipc_dp import pipc_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  request_t request,
  input  ctrl_t    ctrl,
  output stat_t    stat,
  output logic     done,
  output result_t  result
);

  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CB = COORD_BITS;
  localparam int MW = CB + 1;
  localparam int PW = 2 * MW;

  // magnitude of a difference
  function automatic logic [MW-1:0] mag(input logic signed [MW-1:0] v);
    logic [MW-1:0] r;
    r = v[MW-1] ? MW'(-v) : MW'(v);
    return r;
  endfunction

  logic [CW-1:0]        count, count_next;
  logic                 full;
  logic                 wr_en;
  logic signed [CB-1:0] in_x, in_y;

  logic [2*CB-1:0]      mem [MAX_VERTICES];
  logic [2*CB-1:0]      rd_data;
  logic [2*CB-1:0]      prev;
  logic [CW-1:0]        rd_ptr;
  logic                 rd_valid;
  logic                 have_prev;
  logic signed [CB-1:0] px, py;

  assign in_x = request.coord_x[CB-1:0];
  assign in_y = request.coord_y[CB-1:0];
  assign full = (count == CW'(MAX_VERTICES));

  // vertex count update for clear and append
  always_comb begin
    count_next = count;
    if (ctrl.op_done) begin
      unique case (request.command)
        CMD_CLEAR:  count_next = '0;
        CMD_APPEND: if (!full) count_next = count + CW'(1);
        default:    count_next = count;
      endcase
    end
  end

  assign wr_en = ctrl.op_done && (request.command == CMD_APPEND) && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // vertex store, y in the upper half
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {in_y, in_x};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_issue) begin
      rd_data <= mem[rd_ptr[AW-1:0]];
    end
  end

  // query point and read pointer
  always_ff @(posedge clk) begin
    if (ctrl.query_start) begin
      px     <= in_x;
      py     <= in_y;
      rd_ptr <= '0;
    end else if (ctrl.rd_issue) begin
      rd_ptr <= rd_ptr + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      have_prev <= 1'b0;
    end else begin
      rd_valid <= ctrl.rd_issue;
      if (ctrl.query_start) begin
        have_prev <= 1'b0;
      end else if (rd_valid) begin
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      prev <= rd_data;
    end
  end

  // edge stage: crossing test and difference magnitudes
  logic signed [CB-1:0] x0, y0, x1, y1;
  logic signed [MW-1:0] d_px, d_dy, d_py, d_dx;
  logic                 up, down;

  assign x0   = prev[CB-1:0];
  assign y0   = prev[2*CB-1:CB];
  assign x1   = rd_data[CB-1:0];
  assign y1   = rd_data[2*CB-1:CB];
  assign up   = (y0 <= py) && (y1 > py);
  assign down = (y0 > py) && (y1 <= py);
  assign d_px = MW'(px) - MW'(x0);
  assign d_dy = MW'(y1) - MW'(y0);
  assign d_py = MW'(py) - MW'(y0);
  assign d_dx = MW'(x1) - MW'(x0);

  logic          b_valid;
  logic [MW-1:0] b_m_px, b_m_dy, b_m_py, b_m_dx;
  logic          b_ln, b_rn;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= rd_valid && have_prev && (up || down);
    end
  end

  always_ff @(posedge clk) begin
    b_m_px <= mag(d_px);
    b_m_dy <= mag(d_dy);
    b_m_py <= mag(d_py);
    b_m_dx <= mag(d_dx);
    b_ln   <= d_px[MW-1];
    // a downward edge flips the sign of the y offset
    b_rn   <= d_py[MW-1] ^ down ^ d_dx[MW-1];
  end

  // multiply stage
  logic          c_valid;
  logic [PW-1:0] c_pl, c_pr;
  logic          c_ln, c_rn;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    c_pl <= PW'(b_m_px) * PW'(b_m_dy);
    c_pr <= PW'(b_m_py) * PW'(b_m_dx);
    c_ln <= b_ln;
    c_rn <= b_rn;
  end

  // signed compare of the two products, parity count
  logic ln, rn, less, parity;

  assign ln   = c_ln && (c_pl != '0);
  assign rn   = c_rn && (c_pr != '0);
  assign less = (ln != rn) ? ln : (ln ? (c_pl > c_pr) : (c_pl < c_pr));

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 1'b0;
    end else if (ctrl.query_start) begin
      parity <= 1'b0;
    end else if (c_valid && less) begin
      parity <= ~parity;
    end
  end

  // status to controller
  assign stat.few_vertices = (count < CW'(2));
  assign stat.last_issue   = (rd_ptr == count - CW'(1));
  assign stat.pipe_busy    = rd_valid || b_valid || c_valid;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.op_done || ctrl.query_finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op_done || ctrl.query_finish) begin
      result.inside_res   <= ctrl.query_finish && parity;
      result.status       <= ctrl.op_done && (request.command == CMD_APPEND) && full;
      result.vertex_count <= VCOUNT_W'(count_next);
    end
  end

endmodule

[src/point_in_polygon_crossing_top.sv]
// clear, append, unused commands, query on fewer than two vertices: result registered in the
//   cycle after the item is taken, one item a cycle
// query with N stored vertices (N >= 2): one vertex read a cycle in the walk state, then the
//   drain waits for the last read and for crossing edges still in the edge pipeline before
//   the result is registered; busy is low again in the cycle of the result
// results cannot be stalled, done marks each one for a single cycle; synchronous active-high
//   reset empties the store by zeroing the count, no clearing pass
`timescale 1ns / 1ps

module point_in_polygon_crossing_top import pipc_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  pipc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (request.command),
    .stat    (stat),
    .ctrl    (ctrl),
    .busy    (busy)
  );

  // vertex store and edge pipeline
  pipc_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .ctrl    (ctrl),
    .stat    (stat),
    .done    (done),
    .result  (result)
  );

endmodule

[src/pipc_checker.sv]
`timescale 1ns / 1ps
`include "point_in_polygon_crossing_top_macros.svh"

module pipc_checker import pipc_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input request_t request,
  input logic     busy,
  input logic     done,
  input result_t  result
);

  logic accept;
  assign accept = start && !busy;

  // non-query items answer in the next cycle
  `PIPC_ASSERT_NEXT(a_quick_result, clk, rst, accept && (request.command != CMD_QUERY), done)

  // clear leaves an empty store
  `PIPC_ASSERT_NEXT(a_clear_empty, clk, rst, accept && (request.command == CMD_CLEAR), done && (result.vertex_count == '0))

  // a rejected append never carries an inside flag
  `PIPC_ASSERT_NOW(a_reject_not_inside, clk, rst, done && result.status, !result.inside_res)

  // a rejected append reports a full store
  `PIPC_ASSERT_NOW(a_reject_full, clk, rst, done && result.status, result.vertex_count == VCOUNT_W'(MAX_VERTICES))

endmodule

bind point_in_polygon_crossing_top pipc_checker #(
  .MAX_VERTICES (MAX_VERTICES)
) u_pipc_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .request (request),
  .busy    (busy),
  .done    (done),
  .result  (result)
);

[test/pipc_result_checker.sv]
`timescale 1ns / 1ps

module pipc_result_checker import pipc_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  request_t request,
  input  logic     done,
  input  result_t  result,
  output int       fail_count,
  output int       pending,
  output int       inside_seen,
  output int       rejects_seen
);

  // shadow copy of the vertex store
  logic signed [COORD_W-1:0] shadow_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] shadow_y [MAX_VERTICES];
  int                        shadow_count;

  result_t expected_results [$];

  initial begin
    shadow_count = 0;
    fail_count   = 0;
    pending      = 0;
    inside_seen  = 0;
    rejects_seen = 0;
  end

  // exact test: does edge (x0,y0)-(x1,y1) cross the ray going right from (px,py)
  function automatic logic crosses_right(input logic signed [31:0] px, py, x0, y0, x1, y1);
    logic               upward;
    logic               downward;
    logic signed [32:0] dy;
    logic signed [32:0] dy_abs;
    logic signed [32:0] rise;
    logic signed [32:0] run;
    logic signed [32:0] off_x;
    logic signed [66:0] lhs;
    logic signed [66:0] rhs;
    upward   = (y0 <= py) && (y1 > py);
    downward = (y0 > py) && (y1 <= py);
    if (!upward && !downward) return 1'b0;
    dy     = {y1[31], y1} - {y0[31], y0};
    dy_abs = dy[32] ? -dy : dy;
    rise   = {py[31], py} - {y0[31], y0};
    if (dy[32]) rise = -rise;
    run    = {x1[31], x1} - {x0[31], x0};
    off_x  = {px[31], px} - {x0[31], x0};
    // px < x0 + rise * run / |dy|, with the division multiplied out
    lhs = off_x * dy_abs;
    rhs = rise * run;
    return lhs < rhs;
  endfunction

  // apply one command to the shadow store and return the result it must give
  function automatic result_t apply_command(input request_t req);
    result_t     r;
    int unsigned crossings;
    r = '0;
    case (req.command)
      CMD_CLEAR: begin
        shadow_count = 0;
      end
      CMD_APPEND: begin
        if (shadow_count < MAX_VERTICES) begin
          shadow_x[shadow_count] = req.coord_x;
          shadow_y[shadow_count] = req.coord_y;
          shadow_count++;
        end else begin
          r.status = 1'b1;
        end
      end
      CMD_QUERY: begin
        crossings = 0;
        for (int j = 1; j < shadow_count; j++) begin
          if (crosses_right(req.coord_x, req.coord_y, shadow_x[j-1], shadow_y[j-1],
                            shadow_x[j], shadow_y[j]))
            crossings++;
        end
        r.inside_res = crossings[0];
      end
      default: ;
    endcase
    r.vertex_count = shadow_count[VCOUNT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch (%s): expected inside=%0b status=%0b count=%0d, got inside=%0b status=%0b count=%0d",
               $realtime, what, want.inside_res, want.status, want.vertex_count,
               got.inside_res, got.status, got.vertex_count);
  endtask

  // results are checked before the item of the same edge is predicted
  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (done) begin
        if (result.inside_res === 1'b1) inside_seen++;
        if (result.status === 1'b1) rejects_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch("no item waiting", '0, result);
        end else begin
          want = expected_results.pop_front();
          if (result.inside_res !== want.inside_res || result.status !== want.status ||
              result.vertex_count !== want.vertex_count)
            report_mismatch("wrong field", want, result);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_command(request));
      pending = expected_results.size();
    end
  end

endmodule

[test/point_in_polygon_crossing_top_tb.sv]
`timescale 1ns / 1ps

module point_in_polygon_crossing_top_tb;
  import pipc_pkg::*;

  localparam int          MAX_VERTICES = 256;
  localparam logic [31:0] ONE          = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE      = 32'hFFFF_0000;
  localparam logic [31:0] MIN_C        = 32'h8000_0000;
  localparam logic [31:0] MAX_C        = 32'h7FFF_FFFF;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     done;
  result_t  result;

  int fail_count;
  int pending;
  int inside_seen;
  int rejects_seen;

  int items_sent;
  int queries_sent;
  bit quiet;

  // vertices of the current polygon, used to aim query points at ties
  logic [31:0] poly_x [$];
  logic [31:0] poly_y [$];

  point_in_polygon_crossing_top #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (32)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .request(request),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  pipc_result_checker #(
    .MAX_VERTICES(MAX_VERTICES)
  ) checker_i (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .done        (done),
    .result      (result),
    .fail_count  (fail_count),
    .pending     (pending),
    .inside_seen (inside_seen),
    .rejects_seen(rejects_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // mostly back to back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // coordinate within a span: tight around zero, mid range, or any value
  function automatic logic [31:0] rand_coord(input int span);
    int v;
    case (span)
      0: v = int'($urandom_range(0, 512)) - 256;
      1: v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      default: v = int'($urandom());
    endcase
    return v;
  endfunction

  // send one item and hold it until the block takes it
  task automatic send_item(input logic [1:0] cmd, input logic [31:0] x, input logic [31:0] y);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    request <= '{command: cmd, coord_x: x, coord_y: y};
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (cmd == CMD_QUERY) queries_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic add_vertex(input logic [31:0] x, input logic [31:0] y);
    send_item(CMD_APPEND, x, y);
    poly_x.push_back(x);
    poly_y.push_back(y);
  endtask

  task automatic clear_store();
    send_item(CMD_CLEAR, $urandom(), $urandom());
    poly_x.delete();
    poly_y.delete();
  endtask

  // query aimed inside the span, at a vertex coordinate, or anywhere
  task automatic random_query(input int span);
    int          r;
    int          k;
    logic [31:0] qx;
    logic [31:0] qy;
    r  = $urandom_range(0, 99);
    qx = rand_coord(span);
    qy = rand_coord(span);
    if (r >= 70 && r < 90 && poly_x.size() > 0) begin
      k = $urandom_range(0, poly_x.size() - 1);
      if ($urandom_range(0, 2) != 0) qy = poly_y[k];
      if ($urandom_range(0, 2) != 0) qx = poly_x[k];
    end else if (r >= 90) begin
      qx = $urandom();
      qy = $urandom();
    end
    send_item(CMD_QUERY, qx, qy);
  endtask

  task automatic run_random(input int target);
    int sess;
    int full_runs;
    int span;
    int nv;
    int nq;
    int r;
    sess      = 0;
    full_runs = 0;
    while (items_sent < target) begin
      quiet = ($urandom_range(0, 3) == 0);
      span  = $urandom_range(0, 2);
      if (sess == 2 || ($urandom_range(0, 99) < 3 && full_runs < 3)) begin
        // fill the store to the top, then push a few appends that must bounce
        clear_store();
        for (int i = 0; i < MAX_VERTICES; i++) add_vertex(rand_coord(span), rand_coord(span));
        nv = $urandom_range(1, 4);
        for (int i = 0; i < nv; i++) send_item(CMD_APPEND, $urandom(), $urandom());
        nq = $urandom_range(2, 4);
        for (int i = 0; i < nq; i++) random_query(span);
        full_runs++;
      end else begin
        // mostly a closed polygon followed by queries, sometimes left open or stacked
        if ($urandom_range(0, 9) != 0) clear_store();
        nv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        for (int i = 0; i < nv; i++) add_vertex(rand_coord(span), rand_coord(span));
        if (nv > 0 && $urandom_range(0, 99) < 85) add_vertex(poly_x[0], poly_y[0]);
        nq = $urandom_range(1, 8);
        for (int i = 0; i < nq; i++) begin
          r = $urandom_range(0, 99);
          if (r < 6) send_item(CMD_UNUSED, $urandom(), $urandom());
          else if (r < 12) add_vertex($urandom(), $urandom());
          else random_query(span);
        end
      end
      if (sess == 0 || $urandom_range(0, 4) == 0) drain();
      sess++;
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    request      = '0;
    quiet        = 1'b0;
    items_sent   = 0;
    queries_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty and single-vertex queries, unused command
    send_item(CMD_QUERY, 32'd0, 32'd0);
    add_vertex(NEG_ONE, NEG_ONE);
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // unit square, closed by repeating the first vertex
    add_vertex(ONE, NEG_ONE);
    add_vertex(ONE, ONE);
    add_vertex(NEG_ONE, ONE);
    add_vertex(NEG_ONE, NEG_ONE);
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_QUERY, 2 * ONE, 32'd0);
    // point on the crossing x, on a horizontal edge at top and bottom
    send_item(CMD_QUERY, ONE, 32'd0);
    send_item(CMD_QUERY, 32'd0, ONE);
    send_item(CMD_QUERY, 32'd0, NEG_ONE);
    send_item(CMD_QUERY, 32'hFFFE_0000, 32'd0);
    clear_store();
    // polygon at the coordinate extremes
    add_vertex(MIN_C, MIN_C);
    add_vertex(MAX_C, MIN_C);
    add_vertex(MAX_C, MAX_C);
    add_vertex(MIN_C, MAX_C);
    add_vertex(MIN_C, MIN_C);
    send_item(CMD_QUERY, 32'd0, 32'd0);
    send_item(CMD_QUERY, MIN_C, 32'd0);
    send_item(CMD_QUERY, MAX_C, 32'h7FFF_FFFE);
    send_item(CMD_QUERY, MIN_C, MIN_C);
    send_item(CMD_QUERY, MAX_C, MAX_C);
    drain();

    run_random(items_sent + 1750);

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d items, %0d of them queries, %0d found inside",
             items_sent, queries_sent, inside_seen);
    $display("store overflow rejected %0d appends", rejects_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
